// ===== rtl/slaac_pkg.sv =====
// shared types and constants for the address autoconfiguration table
package slaac_pkg;

    localparam logic [2:0] CMD_LINK_LOCAL = 3'd0;
    localparam logic [2:0] CMD_PREFIX_IN  = 3'd1;
    localparam logic [2:0] CMD_FIND       = 3'd2;
    localparam logic [2:0] CMD_GET        = 3'd3;
    localparam logic [2:0] CMD_REMOVE     = 3'd4;
    localparam logic [2:0] CMD_TICK       = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_BUSY = 2'd2;

    localparam logic [1:0] AS_FREE = 2'd0;
    localparam logic [1:0] AS_PREF = 2'd1;
    localparam logic [1:0] AS_DEPR = 2'd2;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_CREATED     = 3'd1;
    localparam logic [2:0] EV_UPDATED     = 3'd2;
    localparam logic [2:0] EV_IGNORED     = 3'd3;
    localparam logic [2:0] EV_DEPRECATED  = 3'd4;
    localparam logic [2:0] EV_INVALIDATED = 3'd5;

    localparam logic [31:0] LIFE_INF     = 32'hFFFF_FFFF;
    localparam logic [63:0] TWO_HOURS_MS = 64'd7200000;
    localparam logic [63:0] LL_HIGH      = 64'hFE80_0000_0000_0000;
    localparam logic [7:0]  LL_LEN       = 8'd10;

    localparam logic [0:0] REG_IID    = 1'd0;
    localparam logic [0:0] REG_ID_LEN = 1'd1;

    // contents of one table slot
    typedef struct packed {
        logic        used;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  plen;
        logic [1:0]  state;
        logic [63:0] vdl;
        logic [63:0] pdl;
        logic [1:0]  inf;
    } slot_t;

    // key and control broadcast to all cells
    typedef struct packed {
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic        by_prefix;
        logic [7:0]  plen;
        logic [63:0] mask_high;
        logic [63:0] mask_low;
        logic [63:0] now;
    } probe_t;

    // match flags that a cell reports to the scan
    typedef struct packed {
        logic hit;
        logic free;
        logic due_inv;
        logic due_dep;
    } flags_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_COUNT,
        S_OUT
    } fsm_t;

    // leading-ones mask of a 64-bit half
    function automatic logic [63:0] lead_mask(input logic [7:0] bits);
        logic [63:0] m;
        m = '0;
        if (bits >= 8'd64) m = '1;
        else if (bits != 8'd0) m = ~(64'hFFFF_FFFF_FFFF_FFFF >> bits[5:0]);
        return m;
    endfunction

endpackage

// ===== rtl/slaac_cell.sv =====
// one table slot: holds its entry, compares it against the probe, reports its match flags
module slaac_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  slaac_pkg::probe_t probe,
    input  logic            wr_en,
    input  slaac_pkg::slot_t  wr_data,
    output slaac_pkg::slot_t  slot,
    output slaac_pkg::flags_t flags
);
    slaac_pkg::slot_t slot_reg;
    logic amatch;

    // slot storage, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg <= '0;
        end else if (wr_en) begin
            slot_reg <= wr_data;
        end
    end

    // compare against the key, by full address or masked prefix
    always_comb begin
        amatch = (((slot_reg.addr_high ^ probe.key_high) & probe.mask_high) == 64'd0)
              && (((slot_reg.addr_low ^ probe.key_low) & probe.mask_low) == 64'd0)
              && (!probe.by_prefix || slot_reg.plen == probe.plen);
        flags.hit     = slot_reg.used && amatch;
        flags.free    = !slot_reg.used;
        flags.due_inv = slot_reg.used && !slot_reg.inf[0] && probe.now >= slot_reg.vdl;
        flags.due_dep = slot_reg.used && slot_reg.state == slaac_pkg::AS_PREF
                     && !slot_reg.inf[1] && probe.now >= slot_reg.pdl;
    end

    assign slot = slot_reg;
endmodule

// ===== rtl/ipv6_slaac_address_table_top.sv =====
// top level of the address autoconfiguration table
// One command is worked at a time: s_tready is high only while the block is idle, so
// a beat can be taken in the cycle after the previous result has left. After the accept
// cycle the row of slot cells is scanned one cell per cycle in index order to find
// the first hit, the first free slot or the first due deadline (the whole row, or
// only the first cell when the command was settled at accept: bad prefix length, ignored
// option, bad identifier, unknown command), then an action step updates the chosen
// slot, then a separate pass over the row counts the used slots, and the result
// is offered until the receiver takes it. A new prefix needs a second scan by the
// formed address plus a second action step.
module ipv6_slaac_address_table_top #(
    parameter int ENTRIES = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, addr_high, addr_low, prefix_length, valid_seconds, preferred_seconds,
    // autonomous, authenticated, now_ms, entry_index, zero pad
    input  logic [247:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, entry, out_addr_high, out_addr_low, valid_deadline,
    // preferred_deadline, address_state, out_prefix_length, address_count,
    // infinite_flags, event_res, two_hour_applied, zero pad
    output logic [287:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // input field slices
    logic [2:0]  in_cmd;
    logic [63:0] in_ah, in_al;
    logic [7:0]  in_plen;
    logic [31:0] in_vs, in_ps, in_now;
    logic        in_aut, in_auth;
    logic [7:0]  in_idx;
    assign in_cmd  = s_tdata[2:0];
    assign in_ah   = s_tdata[66:3];
    assign in_al   = s_tdata[130:67];
    assign in_plen = s_tdata[138:131];
    assign in_vs   = s_tdata[170:139];
    assign in_ps   = s_tdata[202:171];
    assign in_aut  = s_tdata[203];
    assign in_auth = s_tdata[204];
    assign in_now  = s_tdata[236:205];
    assign in_idx  = s_tdata[244:237];

    // configuration registers
    logic [63:0] iid_reg;
    logic [6:0]  id_len_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iid_reg    <= '0;
            id_len_reg <= 7'd64;
        end else if (cfg_valid) begin
            if (cfg_index == slaac_pkg::REG_IID) iid_reg <= cfg_data;
            else id_len_reg <= cfg_data[6:0];
        end
    end

    // held command
    slaac_pkg::fsm_t state_reg, state_next;
    logic [2:0]  cmd_reg;
    logic [63:0] ah_reg, al_reg, now_reg;
    logic [7:0]  plen_reg, idx_reg;
    logic [31:0] vs_reg, ps_reg;
    logic        auth_reg;
    logic [31:0] last_low_reg, clk_high_reg;
    logic        pre_done_reg;
    logic [1:0]  pre_status_reg;
    logic [2:0]  pre_event_reg;
    logic        by_prefix_reg, want_tick_reg;
    logic [IW-1:0] scan_reg;
    logic [CW-1:0] cnt_reg;
    logic        hit_f_reg, free_f_reg, tick_f_reg, tick_inv_reg;
    logic [IW-1:0] hit_i_reg, free_i_reg, tick_i_reg;
    logic [63:0] form_low_reg;

    slaac_pkg::probe_t probe;
    slaac_pkg::slot_t  slots [ENTRIES];
    slaac_pkg::flags_t flags [ENTRIES];
    logic [ENTRIES-1:0] wr_en;
    slaac_pkg::slot_t  wr_data;

    // result register fields
    logic [1:0]  r_status_reg;
    logic [3:0]  r_entry_reg, r_count_reg;
    logic [63:0] r_ah_reg, r_al_reg, r_vd_reg, r_pd_reg;
    logic [1:0]  r_state_reg, r_inf_reg;
    logic [7:0]  r_plen_reg;
    logic [2:0]  r_event_reg;
    logic        r_two_reg, r_cnt_reg;

    // action step signals
    slaac_pkg::slot_t sel, upd;
    logic [IW-1:0] sel_i;
    logic          do_wr, do_pub, rem;
    logic [1:0]    a_status;
    logic [2:0]    a_event;
    logic          a_two, a_again, a_cnt;
    logic [63:0]   now_v, rec, rem_ms, al_new;

    // the probe broadcast to all cells
    always_comb begin
        probe.key_high  = ah_reg;
        probe.key_low   = al_reg;
        probe.by_prefix = by_prefix_reg;
        probe.plen      = plen_reg;
        probe.mask_high = by_prefix_reg ? slaac_pkg::lead_mask(plen_reg) : '1;
        probe.mask_low  = by_prefix_reg ?
            slaac_pkg::lead_mask((plen_reg > 8'd64) ? plen_reg - 8'd64 : 8'd0) : '1;
        probe.now       = now_reg;
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            slaac_cell u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .probe  (probe),
                .wr_en  (wr_en[g]),
                .wr_data(wr_data),
                .slot   (slots[g]),
                .flags  (flags[g])
            );
        end
    endgenerate

    // derived values of the held command
    logic [63:0] iid_val, ll_low, form_low, vs_ms, ps_ms;
    logic        iid_shape_ok;
    always_comb begin
        iid_shape_ok = id_len_reg != 7'd0 && id_len_reg[2:0] == 3'd0
                    && id_len_reg <= 7'd64;
        iid_val  = (id_len_reg >= 7'd64) ? iid_reg
                 : iid_reg & ~(64'hFFFF_FFFF_FFFF_FFFF << id_len_reg[5:0]);
        ll_low   = iid_val;
        form_low = (in_al & ~slaac_pkg::lead_mask(8'd64 - {1'b0, id_len_reg})
                 & slaac_pkg::lead_mask(in_plen - 8'd64)) | iid_val;
        vs_ms    = {32'd0, vs_reg} * 64'd1000;
        ps_ms    = {32'd0, ps_reg} * 64'd1000;
    end

    // clock extension on accept
    logic [31:0] ch_ext;
    assign ch_ext = (in_now < last_low_reg) ? clk_high_reg + 32'd1 : clk_high_reg;

    assign s_tready = state_reg == slaac_pkg::S_IDLE;
    assign m_tvalid = state_reg == slaac_pkg::S_OUT;

    // accept: prechecks that need no scan
    logic        acc;
    logic        ll_pref;
    assign acc = s_tvalid && s_tready;
    assign ll_pref  = in_ah[63:56] == 8'hFE && (in_ah[55:48] & 8'hC0) == 8'h80;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_low_reg <= '0;
            clk_high_reg <= '0;
        end else if (acc && (in_cmd == slaac_pkg::CMD_PREFIX_IN
                          || in_cmd == slaac_pkg::CMD_TICK)) begin
            last_low_reg <= in_now;
            clk_high_reg <= ch_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= slaac_pkg::S_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slaac_pkg::S_IDLE:  if (acc) state_next = slaac_pkg::S_SCAN;
            slaac_pkg::S_SCAN:
                if (pre_done_reg || scan_reg == IW'(ENTRIES - 1))
                    state_next = slaac_pkg::S_ACT;
            slaac_pkg::S_ACT:
                state_next = a_again ? slaac_pkg::S_SCAN : slaac_pkg::S_COUNT;
            slaac_pkg::S_COUNT:
                if (scan_reg == IW'(ENTRIES - 1)) state_next = slaac_pkg::S_OUT;
            slaac_pkg::S_OUT:   if (m_tready) state_next = slaac_pkg::S_IDLE;
            default:            state_next = slaac_pkg::S_IDLE;
        endcase
    end

    // current scanned cell
    slaac_pkg::flags_t cf;
    assign cf  = flags[scan_reg];

    // selected slot for the action step
    always_comb begin
        sel_i = hit_i_reg;
        sel = slots[hit_i_reg];
        upd = sel;
        do_wr = 1'b0; do_pub = 1'b0; rem = 1'b0;
        a_status = pre_status_reg; a_event = pre_event_reg;
        a_two = 1'b0; a_again = 1'b0; a_cnt = pre_event_reg == slaac_pkg::EV_IGNORED;
        now_v = now_reg;
        rec = vs_ms;
        rem_ms = (sel.inf[0] || now_v >= sel.vdl) ? 64'd0 : sel.vdl - now_v;
        al_new = al_reg;
        if (!pre_done_reg) begin
            case (cmd_reg)
                slaac_pkg::CMD_FIND, slaac_pkg::CMD_REMOVE: begin
                    if (hit_f_reg) begin
                        do_pub = 1'b1; a_status = slaac_pkg::ST_OK;
                        if (cmd_reg == slaac_pkg::CMD_REMOVE) begin
                            do_wr = 1'b1; upd = '0; rem = 1'b1;
                        end
                    end
                end
                slaac_pkg::CMD_GET: begin
                    sel_i = idx_reg[IW-1:0];
                    sel = slots[sel_i];
                    upd = sel;
                    if (idx_reg < 8'(ENTRIES) && sel.used) begin
                        do_pub = 1'b1; a_status = slaac_pkg::ST_OK;
                    end
                end
                slaac_pkg::CMD_TICK: begin
                    a_cnt = 1'b1;
                    a_status = slaac_pkg::ST_BUSY;
                    if (tick_f_reg) begin
                        sel_i = tick_i_reg; sel = slots[tick_i_reg]; upd = sel;
                        do_pub = 1'b1; do_wr = 1'b1; a_status = slaac_pkg::ST_OK;
                        if (tick_inv_reg) begin
                            upd = '0; rem = 1'b1; a_event = slaac_pkg::EV_INVALIDATED;
                        end else begin
                            upd.state = slaac_pkg::AS_DEPR;
                            a_cnt = 1'b0; a_event = slaac_pkg::EV_DEPRECATED;
                        end
                    end
                end
                slaac_pkg::CMD_PREFIX_IN: begin
                    if (by_prefix_reg) begin
                        if (hit_f_reg) begin
                            // update existing prefix: two-hour rule then preferred
                            do_wr = 1'b1; do_pub = 1'b1;
                            a_status = slaac_pkg::ST_OK; a_event = slaac_pkg::EV_UPDATED;
                            if (vs_reg == slaac_pkg::LIFE_INF || rec > slaac_pkg::TWO_HOURS_MS
                                || (!sel.inf[0] && rec > rem_ms)) begin
                                upd.inf[0] = vs_reg == slaac_pkg::LIFE_INF;
                                upd.vdl = upd.inf[0] ? 64'd0 : now_v + vs_ms;
                            end else if (!sel.inf[0] && rem_ms <= slaac_pkg::TWO_HOURS_MS) begin
                                if (auth_reg) begin
                                    upd.inf[0] = 1'b0;
                                    upd.vdl = now_v + vs_ms;
                                end else a_two = 1'b1;
                            end else begin
                                upd.inf[0] = 1'b0;
                                upd.vdl = now_v + slaac_pkg::TWO_HOURS_MS;
                                a_two = 1'b1;
                            end
                            upd.inf[1] = ps_reg == slaac_pkg::LIFE_INF;
                            upd.pdl = upd.inf[1] ? 64'd0 : now_v + ps_ms;
                            upd.state = (ps_reg != 32'd0) ? slaac_pkg::AS_PREF
                                                          : slaac_pkg::AS_DEPR;
                        end else begin
                            // new prefix checks, then rescan by full address
                            if (vs_reg == 32'd0
                                || {1'b0, plen_reg} + {2'b0, id_len_reg} != 9'd128) begin
                                a_status = slaac_pkg::ST_OK;
                                a_event = slaac_pkg::EV_IGNORED; a_cnt = 1'b1;
                            end else if (iid_shape_ok) begin
                                a_again = 1'b1;
                                al_new = form_low_reg;
                            end
                        end
                    end else begin
                        if (hit_f_reg) begin
                            do_pub = 1'b1; a_status = slaac_pkg::ST_OK;
                        end else if (!free_f_reg) begin
                            a_status = slaac_pkg::ST_BUSY;
                        end else begin
                            sel_i = free_i_reg; do_wr = 1'b1; do_pub = 1'b1;
                            upd.used = 1'b1; upd.addr_high = ah_reg; upd.addr_low = al_reg;
                            upd.plen = plen_reg;
                            upd.inf[1] = ps_reg == slaac_pkg::LIFE_INF;
                            upd.pdl = upd.inf[1] ? 64'd0 : now_v + ps_ms;
                            upd.state = (ps_reg != 32'd0) ? slaac_pkg::AS_PREF
                                                          : slaac_pkg::AS_DEPR;
                            upd.inf[0] = vs_reg == slaac_pkg::LIFE_INF;
                            upd.vdl = upd.inf[0] ? 64'd0 : now_v + vs_ms;
                            a_status = slaac_pkg::ST_OK; a_event = slaac_pkg::EV_CREATED;
                        end
                    end
                end
                slaac_pkg::CMD_LINK_LOCAL: begin
                    if (hit_f_reg) begin
                        do_pub = 1'b1; a_status = slaac_pkg::ST_OK;
                    end else if (!free_f_reg) begin
                        a_status = slaac_pkg::ST_BUSY;
                    end else begin
                        sel_i = free_i_reg; do_wr = 1'b1; do_pub = 1'b1;
                        upd = '0; upd.used = 1'b1;
                        upd.addr_high = ah_reg; upd.addr_low = al_reg;
                        upd.plen = slaac_pkg::LL_LEN; upd.state = slaac_pkg::AS_PREF;
                        upd.inf = 2'b11;
                        a_status = slaac_pkg::ST_OK; a_event = slaac_pkg::EV_CREATED;
                    end
                end
                default: ;
            endcase
        end
        if (do_pub || rem) a_cnt = 1'b1;
        if (rem) a_cnt = 1'b1;
    end

    assign wr_data = upd;
    always_comb begin
        wr_en = '0;
        if (state_reg == slaac_pkg::S_ACT && do_wr && !a_again) wr_en[sel_i] = 1'b1;
    end

    // datapath sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg <= '0;
        end else begin
            case (state_reg)
                slaac_pkg::S_IDLE: begin
                    if (acc) begin
                        cmd_reg  <= in_cmd;
                        ah_reg   <= in_ah;
                        al_reg   <= in_al;
                        plen_reg <= in_plen;
                        vs_reg   <= in_vs;
                        ps_reg   <= in_ps;
                        auth_reg <= in_auth;
                        idx_reg  <= in_idx;
                        now_reg  <= {ch_ext, in_now};
                        form_low_reg <= form_low;
                        scan_reg <= '0;
                        hit_f_reg <= 1'b0; free_f_reg <= 1'b0; tick_f_reg <= 1'b0;
                        hit_i_reg <= '0; free_i_reg <= '0; tick_i_reg <= '0;
                        tick_inv_reg <= 1'b0;
                        by_prefix_reg <= in_cmd == slaac_pkg::CMD_PREFIX_IN;
                        pre_done_reg <= 1'b1;
                        pre_status_reg <= slaac_pkg::ST_ERR;
                        pre_event_reg <= slaac_pkg::EV_NONE;
                        case (in_cmd)
                            slaac_pkg::CMD_LINK_LOCAL: begin
                                ah_reg <= slaac_pkg::LL_HIGH;
                                al_reg <= ll_low;
                                pre_done_reg <= !(iid_shape_ok
                                    && {2'b0, id_len_reg} + 9'd10 <= 9'd128);
                            end
                            slaac_pkg::CMD_PREFIX_IN: begin
                                if (in_plen <= 8'd128) begin
                                    if (!in_aut || ll_pref || in_ps > in_vs) begin
                                        pre_status_reg <= slaac_pkg::ST_OK;
                                        pre_event_reg  <= slaac_pkg::EV_IGNORED;
                                    end else pre_done_reg <= 1'b0;
                                end
                            end
                            slaac_pkg::CMD_FIND, slaac_pkg::CMD_REMOVE,
                            slaac_pkg::CMD_GET, slaac_pkg::CMD_TICK:
                                pre_done_reg <= 1'b0;
                            default: ;
                        endcase
                        want_tick_reg <= in_cmd == slaac_pkg::CMD_TICK;
                    end
                end
                slaac_pkg::S_SCAN: begin
                    // walk the row one cell per cycle, first match wins
                    if (!hit_f_reg && cf.hit) begin
                        hit_f_reg <= 1'b1; hit_i_reg <= scan_reg;
                    end
                    if (!free_f_reg && cf.free) begin
                        free_f_reg <= 1'b1; free_i_reg <= scan_reg;
                    end
                    if (want_tick_reg && !tick_f_reg && (cf.due_inv || cf.due_dep)) begin
                        tick_f_reg <= 1'b1; tick_i_reg <= scan_reg;
                        tick_inv_reg <= cf.due_inv;
                    end
                    if (scan_reg != IW'(ENTRIES - 1)) scan_reg <= scan_reg + IW'(1);
                end
                slaac_pkg::S_ACT: begin
                    scan_reg <= '0;
                    if (a_again) begin
                        al_reg <= al_new;
                        by_prefix_reg <= 1'b0;
                        hit_f_reg <= 1'b0; free_f_reg <= 1'b0;
                        hit_i_reg <= '0; free_i_reg <= '0;
                    end else begin
                        r_status_reg <= a_status;
                        r_event_reg  <= a_event;
                        r_two_reg    <= a_two;
                        r_cnt_reg    <= a_cnt;
                        r_entry_reg  <= do_pub ? 4'(sel_i) : 4'(ENTRIES);
                        r_ah_reg <= do_pub ? (do_wr && !rem ? upd.addr_high : sel.addr_high)
                                   : ((a_status == slaac_pkg::ST_BUSY
                                      && cmd_reg != slaac_pkg::CMD_TICK) ? ah_reg : 64'd0);
                        r_al_reg <= do_pub ? (do_wr && !rem ? upd.addr_low : sel.addr_low)
                                   : ((a_status == slaac_pkg::ST_BUSY
                                      && cmd_reg != slaac_pkg::CMD_TICK) ? al_reg : 64'd0);
                        r_vd_reg    <= do_pub ? (rem ? sel.vdl : upd.vdl) : 64'd0;
                        r_pd_reg    <= do_pub ? (rem ? sel.pdl : upd.pdl) : 64'd0;
                        r_state_reg <= do_pub ? (rem ? sel.state : upd.state) : 2'd0;
                        r_plen_reg  <= do_pub ? (rem ? sel.plen : upd.plen) : 8'd0;
                        r_inf_reg   <= do_pub ? (rem ? sel.inf : upd.inf) : 2'd0;
                        cnt_reg     <= '0;
                    end
                end
                slaac_pkg::S_COUNT: begin
                    // count used slots after the update
                    if (slots[scan_reg].used) cnt_reg <= cnt_reg + CW'(1);
                    if (scan_reg != IW'(ENTRIES - 1)) scan_reg <= scan_reg + IW'(1);
                    else r_count_reg <= r_cnt_reg ?
                        4'(cnt_reg + CW'(slots[scan_reg].used)) : 4'd0;
                end
                default: ;
            endcase
        end
    end

    assign m_tdata = {6'd0, r_two_reg, r_event_reg, r_inf_reg, r_count_reg,
                      r_plen_reg, r_state_reg, r_pd_reg, r_vd_reg, r_al_reg, r_ah_reg,
                      r_entry_reg, r_status_reg};
endmodule

// ===== tb/tb_ipv6_slaac_address_table_top.sv =====
// testbench for the ipv6 stateless address autoconfiguration table
module tb_ipv6_slaac_address_table_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;
    localparam int CYCLE_LIMIT = 600000;

    // one command beat
    typedef struct {
        logic [2:0]  cmd;
        logic [63:0] ah;
        logic [63:0] al;
        logic [7:0]  plen;
        logic [31:0] vs;
        logic [31:0] ps;
        logic        aut;
        logic        auth;
        logic [31:0] now_ms;
        logic [7:0]  idx;
    } command_t;

    // one result beat
    typedef struct {
        logic [1:0]  status;
        logic [3:0]  entry;
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] vd;
        logic [63:0] pd;
        logic [1:0]  astate;
        logic [7:0]  plen;
        logic [3:0]  count;
        logic [1:0]  inf;
        logic [2:0]  event_res;
        logic        lifetime_cap;
    } answer_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [247:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [287:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [0:0]   cfg_index = slaac_pkg::REG_IID;
    logic [63:0]  cfg_data = '0;

    // table copy used for prediction
    logic        tbl_used [SLOTS];
    logic [63:0] tbl_ah [SLOTS];
    logic [63:0] tbl_al [SLOTS];
    logic [7:0]  tbl_plen [SLOTS];
    logic [1:0]  tbl_state [SLOTS];
    logic [63:0] tbl_vd [SLOTS];
    logic [63:0] tbl_pd [SLOTS];
    logic [1:0]  tbl_inf [SLOTS];
    logic [31:0] clk_low;
    logic [31:0] clk_high;
    logic [63:0] iid;
    logic [6:0]  id_len;

    answer_t     answers_due [$];
    int          errors = 0;
    int          cycles = 0;
    int          hold_left = 0;
    bit          tx_steady = 0;
    bit          rx_steady = 0;
    logic [31:0] wall_ms = 0;
    logic [63:0] prefix_pool [6];

    ipv6_slaac_address_table_top #(.ENTRIES(SLOTS)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold-off, counted down here
    always @(negedge aclk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    // receiver stalls
    always @(negedge aclk) begin
        if (!aresetn || hold_left > 0) m_tready <= 1'b0;
        else if (rx_steady) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) >= 37);
    end

    // ---------------- predictor ----------------

    function automatic logic [63:0] top_ones(input int bits);
        if (bits <= 0) return 64'd0;
        if (bits >= 64) return '1;
        return ~(64'hFFFF_FFFF_FFFF_FFFF >> bits);
    endfunction

    function automatic logic [3:0] used_slots();
        logic [3:0] n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (tbl_used[i]) n++;
        return n;
    endfunction

    function automatic int locate_addr(input logic [63:0] hi, input logic [63:0] lo);
        for (int i = 0; i < SLOTS; i++)
            if (tbl_used[i] && tbl_ah[i] == hi && tbl_al[i] == lo) return i;
        return SLOTS;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < SLOTS; i++) if (!tbl_used[i]) return i;
        return SLOTS;
    endfunction

    function automatic bit iid_fits(input int plen);
        return id_len != 0 && id_len[2:0] == 0 && id_len <= 64
            && plen + int'(id_len) <= 128;
    endfunction

    function automatic logic [63:0] iid_field();
        if (id_len >= 64) return iid;
        return iid & ((64'd1 << id_len) - 64'd1);
    endfunction

    function automatic logic [63:0] extend_clock(input logic [31:0] now_ms);
        if (now_ms < clk_low) clk_high = clk_high + 32'd1;
        clk_low = now_ms;
        return {clk_high, now_ms};
    endfunction

    function automatic void report_slot(inout answer_t r, input int i);
        r.entry = 4'(i);
        r.ah = tbl_ah[i];
        r.al = tbl_al[i];
        r.vd = tbl_vd[i];
        r.pd = tbl_pd[i];
        r.astate = tbl_state[i];
        r.plen = tbl_plen[i];
        r.inf = tbl_inf[i];
        r.count = used_slots();
    endfunction

    function automatic void wipe_slot(input int i);
        tbl_used[i] = 0;
        tbl_ah[i] = 0;
        tbl_al[i] = 0;
        tbl_plen[i] = 0;
        tbl_state[i] = slaac_pkg::AS_FREE;
        tbl_vd[i] = 0;
        tbl_pd[i] = 0;
        tbl_inf[i] = 0;
    endfunction

    function automatic void renew_preferred(input int i, input logic [63:0] now,
                                            input logic [31:0] s);
        tbl_inf[i][1] = (s == slaac_pkg::LIFE_INF);
        tbl_pd[i] = (s == slaac_pkg::LIFE_INF) ? 64'd0 : now + 64'(s) * 64'd1000;
        tbl_state[i] = (s != 0) ? slaac_pkg::AS_PREF : slaac_pkg::AS_DEPR;
    endfunction

    function automatic void renew_valid(input int i, input logic [63:0] now,
                                        input logic [31:0] s);
        tbl_inf[i][0] = (s == slaac_pkg::LIFE_INF);
        tbl_vd[i] = (s == slaac_pkg::LIFE_INF) ? 64'd0 : now + 64'(s) * 64'd1000;
    endfunction

    // link-local or prefix address: reuse a held entry or take a free slot
    function automatic void place_address(inout answer_t r, input int plen,
                                          input logic [63:0] now,
                                          input logic [31:0] vs, input logic [31:0] ps);
        int i;
        i = locate_addr(r.ah, r.al);
        if (i < SLOTS) begin
            report_slot(r, i);
            r.status = slaac_pkg::ST_OK;
            return;
        end
        i = first_free();
        if (i >= SLOTS) begin
            r.status = slaac_pkg::ST_BUSY;
            return;
        end
        tbl_ah[i] = r.ah;
        tbl_al[i] = r.al;
        tbl_plen[i] = 8'(plen);
        tbl_used[i] = 1;
        renew_preferred(i, now, ps);
        renew_valid(i, now, vs);
        report_slot(r, i);
        r.event_res = slaac_pkg::EV_CREATED;
        r.status = slaac_pkg::ST_OK;
    endfunction

    function automatic void apply_prefix(inout answer_t r, input command_t c);
        logic [63:0] now, mh, ml, rec, rem;
        int          plen, i;
        bit          cur_inf;
        now = extend_clock(c.now_ms);
        plen = c.plen;
        if (plen > 128) return;
        if (!c.aut || (c.ah[63:56] == 8'hFE && c.ah[55:54] == 2'b10) || c.ps > c.vs) begin
            r.event_res = slaac_pkg::EV_IGNORED;
            r.count = used_slots();
            r.status = slaac_pkg::ST_OK;
            return;
        end
        mh = top_ones(plen);
        ml = (plen > 64) ? top_ones(plen - 64) : 64'd0;
        i = SLOTS;
        for (int k = SLOTS - 1; k >= 0; k--)
            if (tbl_used[k] && tbl_plen[k] == plen && ((tbl_ah[k] ^ c.ah) & mh) == 0
                && ((tbl_al[k] ^ c.al) & ml) == 0) i = k;
        if (i < SLOTS) begin
            // existing prefix: valid lifetime under the two-hour rule
            cur_inf = tbl_inf[i][0];
            rec = 64'(c.vs) * 64'd1000;
            rem = (cur_inf || now >= tbl_vd[i]) ? 64'd0 : tbl_vd[i] - now;
            if (c.vs == slaac_pkg::LIFE_INF || rec > slaac_pkg::TWO_HOURS_MS
                || (!cur_inf && rec > rem)) begin
                renew_valid(i, now, c.vs);
            end else if (!cur_inf && rem <= slaac_pkg::TWO_HOURS_MS) begin
                if (c.auth) renew_valid(i, now, c.vs);
                else r.lifetime_cap = 1;
            end else begin
                tbl_inf[i][0] = 0;
                tbl_vd[i] = now + slaac_pkg::TWO_HOURS_MS;
                r.lifetime_cap = 1;
            end
            renew_preferred(i, now, c.ps);
            report_slot(r, i);
            r.event_res = slaac_pkg::EV_UPDATED;
            r.status = slaac_pkg::ST_OK;
            return;
        end
        if (c.vs == 0 || plen + int'(id_len) != 128) begin
            r.event_res = slaac_pkg::EV_IGNORED;
            r.count = used_slots();
            r.status = slaac_pkg::ST_OK;
            return;
        end
        if (!iid_fits(plen)) return;
        r.ah = c.ah;
        r.al = (c.al & ~top_ones(64 - int'(id_len)) & top_ones(plen - 64)) | iid_field();
        place_address(r, plen, now, c.vs, c.ps);
    endfunction

    function automatic void run_tick(inout answer_t r, input logic [31:0] now_ms);
        logic [63:0] now;
        now = extend_clock(now_ms);
        for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_used[i]) continue;
            if (!tbl_inf[i][0] && now >= tbl_vd[i]) begin
                report_slot(r, i);
                wipe_slot(i);
                r.count = used_slots();
                r.event_res = slaac_pkg::EV_INVALIDATED;
                r.status = slaac_pkg::ST_OK;
                return;
            end
            if (tbl_state[i] == slaac_pkg::AS_PREF && !tbl_inf[i][1] && now >= tbl_pd[i]) begin
                tbl_state[i] = slaac_pkg::AS_DEPR;
                report_slot(r, i);
                r.event_res = slaac_pkg::EV_DEPRECATED;
                r.status = slaac_pkg::ST_OK;
                return;
            end
        end
        r.count = used_slots();
        r.status = slaac_pkg::ST_BUSY;
    endfunction

    function automatic answer_t predict_command(input command_t c);
        answer_t r;
        int      i;
        r = '{default: '0};
        r.status = slaac_pkg::ST_ERR;
        r.entry = 4'(SLOTS);
        case (c.cmd)
            slaac_pkg::CMD_LINK_LOCAL: begin
                if (iid_fits(slaac_pkg::LL_LEN)) begin
                    r.ah = slaac_pkg::LL_HIGH;
                    r.al = iid_field();
                    place_address(r, slaac_pkg::LL_LEN, 64'd0, slaac_pkg::LIFE_INF,
                                  slaac_pkg::LIFE_INF);
                end
            end
            slaac_pkg::CMD_PREFIX_IN: apply_prefix(r, c);
            slaac_pkg::CMD_FIND, slaac_pkg::CMD_REMOVE: begin
                i = locate_addr(c.ah, c.al);
                if (i < SLOTS) begin
                    report_slot(r, i);
                    if (c.cmd == slaac_pkg::CMD_REMOVE) begin
                        wipe_slot(i);
                        r.count = used_slots();
                    end
                    r.status = slaac_pkg::ST_OK;
                end
            end
            slaac_pkg::CMD_GET: begin
                if (c.idx < SLOTS && tbl_used[c.idx]) begin
                    report_slot(r, c.idx);
                    r.status = slaac_pkg::ST_OK;
                end
            end
            slaac_pkg::CMD_TICK: run_tick(r, c.now_ms);
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(input string nm, input logic [63:0] e,
                                        input logic [63:0] a);
        if (a !== e) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, nm, e, a);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        logic [287:0] v;
        answer_t      e;
        if (aresetn && m_tvalid && m_tready) begin
            v = m_tdata;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, m_tdata);
                errors++;
            end else begin
                e = answers_due.pop_front();
                check_field("status", e.status, v[1:0]);
                check_field("entry", e.entry, v[5:2]);
                check_field("out_addr_high", e.ah, v[69:6]);
                check_field("out_addr_low", e.al, v[133:70]);
                check_field("valid_deadline", e.vd, v[197:134]);
                check_field("preferred_deadline", e.pd, v[261:198]);
                check_field("address_state", e.astate, v[263:262]);
                check_field("out_prefix_length", e.plen, v[271:264]);
                check_field("address_count", e.count, v[275:272]);
                check_field("infinite_flags", e.inf, v[277:276]);
                check_field("event_res", e.event_res, v[280:278]);
                check_field("lifetime_cap", e.lifetime_cap, v[281]);
            end
        end
    end

    // ---------------- drivers ----------------

    // send one command beat; entered and left at a falling edge
    task automatic send_command(input command_t c);
        if (!tx_steady && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tdata <= {3'd0, c.idx, c.now_ms, c.auth, c.aut, c.ps, c.vs, c.plen,
                    c.al, c.ah, c.cmd};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        answers_due.push_back(predict_command(c));
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [63:0] value);
        wait_drained();
        cfg_index <= index;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (index == slaac_pkg::REG_IID) iid = value;
        else id_len = value[6:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic command_t blank_command(input logic [2:0] cmd);
        command_t c;
        c = '{default: '0};
        c.cmd = cmd;
        c.now_ms = wall_ms;
        return c;
    endfunction

    function automatic command_t prefix_command(input logic [63:0] hi, input logic [63:0] lo,
                                                input int plen, input logic [31:0] vs,
                                                input logic [31:0] ps, input bit auth);
        command_t c;
        c = blank_command(slaac_pkg::CMD_PREFIX_IN);
        c.ah = hi;
        c.al = lo;
        c.plen = 8'(plen);
        c.vs = vs;
        c.ps = ps;
        c.aut = 1;
        c.auth = auth;
        return c;
    endfunction

    function automatic command_t lookup_command(input logic [2:0] cmd);
        command_t c;
        int       k;
        c = blank_command(cmd);
        k = $urandom_range(0, SLOTS - 1);
        if (tbl_used[k] && $urandom_range(0, 9) < 8) begin
            c.ah = tbl_ah[k];
            c.al = tbl_al[k];
        end else begin
            c.ah = {$urandom, $urandom};
            c.al = {$urandom, $urandom};
        end
        return c;
    endfunction

    function automatic command_t noise_command();
        command_t c;
        c.cmd = 3'($urandom);
        c.ah = {$urandom, $urandom};
        c.al = {$urandom, $urandom};
        c.plen = 8'($urandom);
        c.vs = $urandom;
        c.ps = $urandom;
        c.aut = 1'($urandom);
        c.auth = 1'($urandom);
        c.now_ms = $urandom;
        c.idx = 8'($urandom);
        return c;
    endfunction

    // ---------------- tests ----------------

    task automatic test_directed();
        logic [63:0] pfx;
        pfx = 64'h2001_0db8_0000_0001;
        send_command(blank_command(slaac_pkg::CMD_TICK));
        send_command(blank_command(slaac_pkg::CMD_LINK_LOCAL));
        send_command(blank_command(slaac_pkg::CMD_LINK_LOCAL));
        send_command(prefix_command(pfx, '1, 64, 30, 10, 0));
        send_command(prefix_command(pfx, 0, 64, 20, 10, 0));
        send_command(prefix_command(pfx, 0, 64, 20, 10, 1));
        send_command(prefix_command(pfx, 0, 64, 9000, 9000, 0));
        send_command(prefix_command(pfx, 0, 64, slaac_pkg::LIFE_INF, slaac_pkg::LIFE_INF, 0));
        send_command(prefix_command(pfx, 0, 64, 100, 50, 0));
        send_command(prefix_command(pfx, 0, 255, 5, 5, 0));
        send_command(prefix_command(slaac_pkg::LL_HIGH, 0, 64, 5, 5, 0));
        send_command(prefix_command(pfx + 1, 0, 64, 5, 9, 0));
        send_command(prefix_command(pfx + 1, 0, 64, 0, 0, 0));
        send_command(prefix_command(pfx + 1, 0, 48, 5, 5, 0));
        send_command(prefix_command(pfx + 2, 0, 64, 3, 0, 0));
        begin
            command_t c;
            c = prefix_command(pfx + 3, 0, 64, 5, 5, 0);
            c.aut = 0;
            send_command(c);
            c = blank_command(slaac_pkg::CMD_GET);
            c.idx = 8'hFF;
            send_command(c);
            c.idx = 0;
            send_command(c);
            c = blank_command(slaac_pkg::CMD_FIND);
            c.ah = slaac_pkg::LL_HIGH;
            send_command(c);
            c.cmd = slaac_pkg::CMD_REMOVE;
            send_command(c);
            send_command(c);
            c.cmd = 3'd6;
            send_command(c);
            c.cmd = 3'd7;
            send_command(c);
        end
        wall_ms = 32'd4000;
        send_command(blank_command(slaac_pkg::CMD_TICK));
        wall_ms = 32'd0;
        send_command(blank_command(slaac_pkg::CMD_TICK));
    endtask

    task automatic random_commands(input int n);
        command_t    c;
        int          pick, plen;
        logic [31:0] vs;
        for (int k = 0; k < n; k++) begin
            wall_ms = wall_ms + $urandom_range(0, 3000);
            if ($urandom_range(0, 199) == 0) wall_ms = 32'hFFFF_F000 + $urandom_range(0, 4000);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                plen = ($urandom_range(0, 9) < 9) ? 128 - int'(id_len) : $urandom_range(0, 140);
                case ($urandom_range(0, 4))
                    0, 1: vs = $urandom_range(0, 20);
                    2: vs = $urandom_range(7000, 7400);
                    3: vs = slaac_pkg::LIFE_INF;
                    default: vs = $urandom;
                endcase
                c = prefix_command(prefix_pool[$urandom_range(0, 5)],
                                   {$urandom, $urandom}, plen, vs, 0, 1'($urandom));
                c.ps = ($urandom_range(0, 9) == 0) ? $urandom
                     : (vs == slaac_pkg::LIFE_INF && $urandom_range(0, 1)) ? slaac_pkg::LIFE_INF
                     : $urandom_range(0, vs > 30000 ? 30000 : vs);
                if ($urandom_range(0, 19) == 0) c.aut = 0;
            end else if (pick < 55) c = blank_command(slaac_pkg::CMD_TICK);
            else if (pick < 65) c = lookup_command(slaac_pkg::CMD_FIND);
            else if (pick < 75) begin
                c = blank_command(slaac_pkg::CMD_GET);
                c.idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 9));
            end else if (pick < 85) c = lookup_command(slaac_pkg::CMD_REMOVE);
            else if (pick < 90) c = blank_command(slaac_pkg::CMD_LINK_LOCAL);
            else begin
                c = noise_command();
                wall_ms = c.now_ms;
            end
            send_command(c);
        end
    endtask

    task automatic test_identifier_settings();
        write_register(slaac_pkg::REG_IID, {$urandom, $urandom});
        random_commands(300);
        write_register(slaac_pkg::REG_ID_LEN, 64'd56);
        random_commands(300);
        write_register(slaac_pkg::REG_IID, '1);
        write_register(slaac_pkg::REG_ID_LEN, 64'd8);
        random_commands(250);
        write_register(slaac_pkg::REG_ID_LEN, 64'd0);
        random_commands(60);
        write_register(slaac_pkg::REG_ID_LEN, 64'd12);
        random_commands(60);
        write_register(slaac_pkg::REG_ID_LEN, 64'd127);
        random_commands(60);
        write_register(slaac_pkg::REG_IID, 64'd0);
        write_register(slaac_pkg::REG_ID_LEN, 64'd64);
        random_commands(300);
    endtask

    task automatic test_no_idle_stretch();
        tx_steady = 1;
        rx_steady = 1;
        random_commands(250);
        tx_steady = 0;
        rx_steady = 0;
    endtask

    task automatic test_backpressure();
        tx_steady = 1;
        hold_left = 300;
        random_commands(40);
        tx_steady = 0;
        random_commands(250);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) wipe_slot(i);
        clk_low = 0;
        clk_high = 0;
        iid = 0;
        id_len = 7'd64;
        for (int i = 0; i < 6; i++) prefix_pool[i] = {$urandom, $urandom};
        prefix_pool[0] = slaac_pkg::LL_HIGH | 64'h0000_0000_0000_1234;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_identifier_settings();
        test_no_idle_stretch();
        test_backpressure();
        wait_drained();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule
